// ===== sv/sphc_pkg.sv =====
// Shared constants for the sphere-sphere contact generator.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package sphc_pkg;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam logic [15:0] CAPACITY_RESET = 16'd256;
    localparam int OPND_W = 32;
    localparam int S_DATA_W = 256;
    localparam int M_DATA_W = 184;
    localparam int M_USER_W = 2;
endpackage
`default_nettype wire

// ===== sv/sphere_sphere_contact.sv =====
// Sphere-sphere contact generator.
// Input words on s_tdata carry two spheres (centre and radius, Q16.16); one
// result word leaves on m_tdata/m_tuser for every input word, in order.
// The contact budget register is written on cfg_valid/cfg_data (always ready)
// and must only be written while the block is idle.
// One item at a time: s_tready is high only when the block is idle. A pair
// that hits uses the shared multiplier (three squares and the squared radius
// sum), then the square-root unit, then the divider once per normal
// component, and then the result is latched. Pairs that miss finish after
// the multiplier; a used-up budget goes straight to the output.
// The result is held on m_tdata until m_tready; the next word is taken only
// after that. Reset (aresetn low, synchronous) empties the block, clears the
// contact count and sets the capacity to 256.
// Depends on sphc_pkg, sphc_mul, sphc_sqrt and sphc_div.
`default_nettype none
module sphere_sphere_contact #(
    parameter int FRAC_BITS = sphc_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // first_x, first_y, first_z, first_radius, second_x, second_y,
    // second_z, second_radius
    input  wire logic [sphc_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // normal_x, normal_y, normal_z, point_x, point_y, point_z, depth
    output logic      [sphc_pkg::M_DATA_W-1:0]   m_tdata,
    // hit, budget_full
    output logic      [sphc_pkg::M_USER_W-1:0]   m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [15:0]                     cfg_data
);
    localparam int W  = sphc_pkg::OPND_W;
    localparam int QW = FRAC_BITS + 1;
    localparam int EW = (QW > 18) ? QW : 18;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  comp_reg, comp_next;
    logic [15:0] cap_reg, used_reg, used_next;

    logic signed [W-1:0] a_reg [3];
    logic signed [W:0]   d_reg [3];
    logic [W-1:0]        rsum_reg;
    logic [2*W+1:0]      s_reg, s_next;
    logic [W-1:0]        len_reg;
    logic [QW-1:0]       q_reg [3];

    logic [sphc_pkg::M_DATA_W-1:0] tdata_reg, tdata_next;
    logic [sphc_pkg::M_USER_W-1:0] tuser_reg, tuser_next;

    logic [W-1:0]   mag [3];
    logic [W-1:0]   mul_a;
    logic [2*W-1:0] prod;
    logic           sqrt_start, sqrt_done, div_start, div_done;
    logic [W-1:0]   root;
    logic [1:0]     div_idx;
    logic [QW-1:0]  quot;
    logic           accept;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_OUT) && (cnt_reg != 3'd5);
    assign m_tdata   = tdata_reg;
    assign m_tuser   = tuser_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = d_reg[i][W] ? W'(-d_reg[i]) : d_reg[i][W-1:0];
        end
    end

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    mul_a = mag[0];
            2'd1:    mul_a = mag[1];
            2'd2:    mul_a = mag[2];
            default: mul_a = rsum_reg;
        endcase
    end

    sphc_mul u_mul (
        .aclk     (aclk),
        .a        (mul_a),
        .b        (mul_a),
        .prod_reg (prod)
    );

    sphc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (s_reg[2*W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    sphc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (mag[div_idx]),
        .den      (len_reg),
        .done     (div_done),
        .quot_reg (quot)
    );

    // Final result fields from the registered intermediate values.
    logic [17:0]         nrm [3];
    logic [W-1:0]        pnt [3];
    logic [EW-1:0]       qe;
    logic [17:0]         qc;
    logic signed [W+1:0] psum;
    logic [W-1:0]        dep_full;
    logic [W-2:0]        dep;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qe = EW'(q_reg[i]);
            qc = (qe > EW'(131072)) ? 18'h20000 : qe[17:0];
            if (d_reg[i][W]) begin
                nrm[i] = -qc;
            end else begin
                nrm[i] = (qc == 18'h20000) ? 18'h1FFFF : qc;
            end
            psum = (W+2)'(a_reg[i]) + (W+2)'(d_reg[i] >>> 1);
            if (psum > (W+2)'(32'sh7FFFFFFF)) begin
                pnt[i] = 32'h7FFFFFFF;
            end else if (psum < -(W+2)'(34'sh80000000)) begin
                pnt[i] = 32'h80000000;
            end else begin
                pnt[i] = psum[W-1:0];
            end
        end
        dep_full = rsum_reg - len_reg;
        dep      = dep_full[W-1] ? {(W-1){1'b1}} : dep_full[W-2:0];
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        used_next  = used_reg;
        s_next     = s_reg;
        tdata_next = tdata_reg;
        tuser_next = tuser_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        div_idx    = comp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next = '0;
                    s_next   = '0;
                    if (used_reg >= cap_reg) begin
                        tdata_next = '0;
                        tuser_next = 2'b10;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg >= 3'd1 && cnt_reg <= 3'd3) begin
                    s_next = s_reg + (2*W+2)'(prod);
                end
                if (cnt_reg == 3'd4) begin
                    if (s_reg == '0 || s_reg >= (2*W+2)'(prod)) begin
                        tdata_next = '0;
                        tuser_next = 2'b00;
                        cnt_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        sqrt_start = 1'b1;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    comp_next  = 2'd0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    div_start = 1'b1;
                    cnt_next  = 3'd1;
                end else if (div_done) begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2) begin
                        state_next = ST_OUT;
                        cnt_next   = 3'd5;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
            end
            ST_OUT: begin
                if (cnt_reg == 3'd5) begin
                    // Results of a hit are latched in ST_OUT, after the divider has written the last component.
                    tdata_next = {3'b000, dep, pnt[2], pnt[1], pnt[0],
                                  nrm[2], nrm[1], nrm[0]};
                    tuser_next = 2'b01;
                    cnt_next   = '0;
                    if (used_reg != 16'hFFFF) begin
                        used_next = used_reg + 16'd1;
                    end
                end else if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // m_tvalid is gated until the hit payload is latched.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            used_reg  <= '0;
            cap_reg   <= sphc_pkg::CAPACITY_RESET;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            used_reg  <= used_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
        end
        s_reg     <= s_next;
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
        if (accept) begin
            a_reg[0] <= s_tdata[31:0];
            a_reg[1] <= s_tdata[63:32];
            a_reg[2] <= s_tdata[95:64];
            d_reg[0] <= (W+1)'($signed(s_tdata[31:0]))   - (W+1)'($signed(s_tdata[158:127]));
            d_reg[1] <= (W+1)'($signed(s_tdata[63:32]))  - (W+1)'($signed(s_tdata[190:159]));
            d_reg[2] <= (W+1)'($signed(s_tdata[95:64]))  - (W+1)'($signed(s_tdata[222:191]));
            rsum_reg <= W'(s_tdata[126:96]) + W'(s_tdata[253:223]);
        end
        if (sqrt_done) begin
            len_reg <= root;
        end
        if (state_reg == ST_DIV && div_done) begin
            q_reg[comp_reg] <= quot;
        end
    end
endmodule
`default_nettype wire

// ===== sv/sphc_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on sphc_pkg for the operand width.
`default_nettype none
module sphc_mul (
    input  wire logic                              aclk,
    input  wire logic [sphc_pkg::OPND_W-1:0]       a,
    input  wire logic [sphc_pkg::OPND_W-1:0]       b,
    output logic      [2*sphc_pkg::OPND_W-1:0]     prod_reg
);
    logic [2*sphc_pkg::OPND_W-1:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end
endmodule
`default_nettype wire

// ===== sv/sphc_sqrt.sv =====
// Bit-pair restoring integer square root of a 64-bit value, one step a cycle.
// Depends on sphc_pkg for the result width.
`default_nettype none
module sphc_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [2*sphc_pkg::OPND_W-1:0] radicand,
    output logic                               done,
    output logic      [sphc_pkg::OPND_W-1:0]   root
);
    localparam int W = 2 * sphc_pkg::OPND_W;

    logic [W-1:0] s_reg, s_next, r_reg, r_next, bit_reg, bit_next, rb;
    logic [4:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;

    assign rb = r_reg + bit_reg;

    always_comb begin
        s_next    = s_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            s_next    = radicand;
            r_next    = '0;
            bit_next  = {2'b01, {(W-2){1'b0}}};
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (s_reg >= rb) begin
                s_next = s_reg - rb;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
            end
        end
    end

    // The root is final in the cycle after the last step.
    logic fin_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= busy_reg && !busy_next && !start;
            cnt_reg  <= cnt_next;
        end
        s_reg   <= s_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign root = r_reg[sphc_pkg::OPND_W-1:0];

    always_comb begin
        done = fin_reg;
    end
endmodule
`default_nettype wire

// ===== sv/sphc_div.sv =====
// Restoring divider for one normal component: (num << FRAC_BITS) / den,
// where num <= den, one quotient bit a cycle. Depends on sphc_pkg.
`default_nettype none
module sphc_div #(
    parameter int FRAC_BITS = sphc_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [sphc_pkg::OPND_W-1:0] num,
    input  wire logic [sphc_pkg::OPND_W-1:0] den,
    output logic                             done,
    output logic      [FRAC_BITS:0]          quot_reg
);
    localparam int W  = sphc_pkg::OPND_W;
    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [W:0]          rem_reg, rem_next, t;
    logic [W-1:0]        den_reg, den_next;
    logic [FRAC_BITS:0]  quot_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next, fin_reg, fin_next;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        t         = (cnt_reg == '0) ? rem_reg : {rem_reg[W-1:0], 1'b0};
        if (start) begin
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (t >= {1'b0, den_reg}) begin
                rem_next  = t - {1'b0, den_reg};
                quot_next = {quot_reg[FRAC_BITS-1:0], 1'b1};
            end else begin
                rem_next  = t;
                quot_next = {quot_reg[FRAC_BITS-1:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(FRAC_BITS)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = fin_reg;
endmodule
`default_nettype wire
